// ----- sv/frs_pkg.sv -----
// Package for the flow RTT statistics histogram block.
// Types, sizing constants, controller/datapath structs and the bucket function.
// No dependencies.
package frs_pkg;

  localparam int FLOW_ENTRIES = 1024;
  localparam int HIST_BUCKETS = 27;

  localparam int IDX_W   = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(FLOW_ENTRIES + 1);
  localparam int HADDR_W = (FLOW_ENTRIES * HIST_BUCKETS > 1) ?
                           $clog2(FLOW_ENTRIES * HIST_BUCKETS) : 1;
  localparam int BKT_W   = 5;
  localparam int RTT_W   = 29;
  localparam int KEY_W   = 96;

  typedef struct packed {
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] smoothed_rtt_x8;
  } frs_in_t;

  typedef struct packed {
    logic [RTT_W-1:0] rtt_sample_us;
    logic [63:0]      sample_count;
    logic [63:0]      rtt_sum_us;
    logic [RTT_W-1:0] rtt_min_us;
    logic [RTT_W-1:0] rtt_max_us;
    logic [BKT_W-1:0] bucket_index;
    logic [31:0]      bucket_count;
    logic             new_flow;
    logic             table_full_drop;
  } frs_out_t;

  // per-entry stats word; bkt_seen marks buckets written since insert
  typedef struct packed {
    logic [63:0]             sum;
    logic [63:0]             count;
    logic [RTT_W-1:0]        min;
    logic [RTT_W-1:0]        max;
    logic [HIST_BUCKETS-1:0] bkt_seen;
  } frs_stats_t;

  typedef struct packed {
    logic load;
    logic scan_inc;
    logic set_hit;
    logic set_new;
    logic set_drop;
    logic calc_addr;
    logic commit;
  } frs_cmd_t;

  typedef struct packed {
    logic zero_in;
    logic scan_end;
    logic key_match;
    logic full;
    logic out_busy;
  } frs_sts_t;

  // floor(log2(v)) by binary search, capped at last bucket
  function automatic logic [BKT_W-1:0] bucket_of(input logic [RTT_W-1:0] x);
    logic [RTT_W-1:0] v;
    logic [BKT_W-1:0] r;
    v = x;
    r = '0;
    if (|v[28:16]) begin r = r | BKT_W'(16); v = v >> 16; end
    if (|v[15:8])  begin r = r | BKT_W'(8);  v = v >> 8;  end
    if (|v[7:4])   begin r = r | BKT_W'(4);  v = v >> 4;  end
    if (|v[3:2])   begin r = r | BKT_W'(2);  v = v >> 2;  end
    if (v[1])      begin r = r | BKT_W'(1);  end
    if (r > BKT_W'(HIST_BUCKETS - 1)) r = BKT_W'(HIST_BUCKETS - 1);
    return r;
  endfunction

endpackage

// ----- sv/frs_in_if.sv -----
// Input channel interface: valid/ready plus one sample word.
// Depends on frs_pkg.
interface frs_in_if;
  logic           valid;
  logic           ready;
  frs_pkg::frs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/frs_out_if.sv -----
// Result channel interface: valid/ready plus one statistics word.
// Depends on frs_pkg.
interface frs_out_if;
  logic            valid;
  logic            ready;
  frs_pkg::frs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/frs_ctrl.sv -----
// Controller FSM: accept, linear key scan, stats read, commit.
// Depends on frs_pkg.
module frs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  frs_pkg::frs_sts_t sts,
  output frs_pkg::frs_cmd_t cmd
);
  import frs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_ADDR = 6'b001000,
    S_URD  = 6'b010000,
    S_WR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.zero_in) state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (sts.scan_end) begin
          if (sts.full) begin
            cmd.set_drop = 1'b1;
            state_nxt    = S_WR;
          end else begin
            cmd.set_new = 1'b1;
            state_nxt   = S_ADDR;
          end
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.key_match) begin
          cmd.set_hit = 1'b1;
          state_nxt   = S_ADDR;
        end else begin
          cmd.scan_inc = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_ADDR: begin
        cmd.calc_addr = 1'b1;
        state_nxt     = S_URD;
      end
      S_URD: state_nxt = S_WR;
      S_WR: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ----- sv/frs_dp.sv -----
// Datapath: key, stats and histogram memories, fill count, output register.
// Depends on frs_pkg, frs_out_if.
module frs_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  frs_pkg::frs_in_t  in_data,
  input  frs_pkg::frs_cmd_t cmd,
  output frs_pkg::frs_sts_t sts,
  frs_out_if.source         out_ch
);
  import frs_pkg::*;

  logic [KEY_W-1:0] key_mem   [FLOW_ENTRIES];
  frs_stats_t       stats_mem [FLOW_ENTRIES];
  logic [31:0]      hist_mem  [FLOW_ENTRIES*HIST_BUCKETS];

  logic [KEY_W-1:0]   key_r, key_rd_r;
  logic [RTT_W-1:0]   rtt_r;
  logic [BKT_W-1:0]   bkt_r;
  logic [CNT_W-1:0]   fill_r, scan_r;
  logic [IDX_W-1:0]   ent_r;
  logic [HADDR_W-1:0] haddr_r;
  logic               new_r, drop_r;
  frs_stats_t         st_rd_r, st_new;
  logic [31:0]        hist_rd_r, hist_new;
  logic [RTT_W-1:0]   in_rtt;
  frs_out_t           out_r, out_nxt;
  logic               out_valid_r;

  assign in_rtt = in_data.smoothed_rtt_x8[31:3];

  assign sts.zero_in   = (in_rtt == '0);
  assign sts.scan_end  = (scan_r == fill_r);
  assign sts.key_match = (key_rd_r == key_r);
  assign sts.full      = (fill_r == CNT_W'(FLOW_ENTRIES));
  assign sts.out_busy  = out_valid_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= {in_data.source_ip, in_data.dest_ip, in_data.source_port,
                in_data.dest_port};
      rtt_r <= in_rtt;
      bkt_r <= bucket_of(in_rtt);
    end
    if (cmd.set_hit) ent_r <= scan_r[IDX_W-1:0];
    if (cmd.set_new) ent_r <= fill_r[IDX_W-1:0];
    if (cmd.calc_addr)
      haddr_r <= HADDR_W'(ent_r) * HADDR_W'(HIST_BUCKETS) + HADDR_W'(bkt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      new_r  <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r <= '0;
        new_r  <= 1'b0;
        drop_r <= 1'b0;
      end else if (cmd.scan_inc) begin
        scan_r <= scan_r + CNT_W'(1);
      end
      if (cmd.set_new)  new_r  <= 1'b1;
      if (cmd.set_drop) drop_r <= 1'b1;
    end
  end

  // entries fill from index 0 and are never freed: valid == index < fill
  always_ff @(posedge clk) begin
    if (!rst_n)                        fill_r <= '0;
    else if (cmd.commit && new_r)      fill_r <= fill_r + CNT_W'(1);
  end

  // memories
  always_ff @(posedge clk) begin
    key_rd_r  <= key_mem[scan_r[IDX_W-1:0]];
    st_rd_r   <= stats_mem[ent_r];
    hist_rd_r <= hist_mem[haddr_r];
    if (cmd.commit && !drop_r) begin
      stats_mem[ent_r] <= st_new;
      hist_mem[haddr_r] <= hist_new;
      if (new_r) key_mem[ent_r] <= key_r;
    end
  end

  always_comb begin
    logic [HIST_BUCKETS-1:0] bit_b;
    bit_b = HIST_BUCKETS'(1) << bkt_r;
    if (new_r) begin
      st_new.sum      = 64'(rtt_r);
      st_new.count    = 64'd1;
      st_new.min      = rtt_r;
      st_new.max      = rtt_r;
      st_new.bkt_seen = bit_b;
      hist_new        = 32'd1;
    end else begin
      st_new.sum      = st_rd_r.sum + 64'(rtt_r);
      st_new.count    = st_rd_r.count + 64'd1;
      st_new.min      = (rtt_r < st_rd_r.min || st_rd_r.min == '0) ? rtt_r : st_rd_r.min;
      st_new.max      = (rtt_r > st_rd_r.max) ? rtt_r : st_rd_r.max;
      st_new.bkt_seen = st_rd_r.bkt_seen | bit_b;
      // a bucket not touched since insert reads as cleared
      hist_new        = ((|(st_rd_r.bkt_seen & bit_b)) ? hist_rd_r : 32'd0) + 32'd1;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (drop_r) begin
      out_nxt.table_full_drop = 1'b1;
    end else begin
      out_nxt.rtt_sample_us = rtt_r;
      out_nxt.sample_count  = st_new.count;
      out_nxt.rtt_sum_us    = st_new.sum;
      out_nxt.rtt_min_us    = st_new.min;
      out_nxt.rtt_max_us    = st_new.max;
      out_nxt.bucket_index  = bkt_r;
      out_nxt.bucket_count  = hist_new;
      out_nxt.new_flow      = new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FLOW_ENTRIES))
    else $error("fill count above table size");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.out_busy)
    else $error("commit while output word not taken");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && drop_r) |-> sts.full && !new_r)
    else $error("drop with free entry");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && new_r) |=> fill_r == $past(fill_r) + CNT_W'(1))
    else $error("insert did not grow fill count");

endmodule

// ----- sv/flow_rtt_stats_histogram.sv -----
// Top level of the per-flow RTT statistics histogram block.
// Depends on frs_pkg, frs_in_if, frs_out_if, frs_ctrl, frs_dp.
//
//   channel  dir  word
//   in_ch    in   flow 4-tuple + smoothed RTT x8
//   out_ch   out  updated flow statistics, one word per nonzero sample
//
// Accept to commit: a hit scans the flows stored ahead of the match, then steps
// through S_ADDR, S_URD and S_WR; a new flow scans all stored flows and takes
// the same steps; a table-full drop scans all and goes to S_WR. The key scan
// reads then compares one key entry at a time; a zero sample is dropped in S_IDLE.
// Synchronous active-low reset empties the table through the fill count; no
// clearing pass. A result waiting in the output register does not block the
// next accept; only the commit step waits for it to be taken.
module flow_rtt_stats_histogram (
  input  logic      clk,
  input  logic      rst_n,
  frs_in_if.sink    in_ch,
  frs_out_if.source out_ch
);
  import frs_pkg::*;

  frs_cmd_t cmd;
  frs_sts_t sts;

  frs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  frs_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_ch.data),
    .cmd     (cmd),
    .sts     (sts),
    .out_ch  (out_ch)
  );

endmodule
